@@ src/device_id_allow_list_table_core_macros.svh @@
// assertion macros for the device id allow-list table
// used by device_id_allow_list_table_core; needs clk and rst in scope
`ifndef DEVICE_ID_ALLOW_LIST_TABLE_CORE_MACROS_SVH
`define DEVICE_ID_ALLOW_LIST_TABLE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define DALT_CHK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define DALT_CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define DALT_CHK(lbl, cond, msg)
`define DALT_CHK_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ src/dalt_pkg.sv @@
// shared types and constants for the device id allow-list table
// no dependencies
package dalt_pkg;

  localparam int MaxRulesDef = 16;
  localparam int SnBytes     = 8;

  localparam int InDataW  = 120;
  localparam int InUserW  = 3;
  localparam int OutDataW = 128;

  typedef enum logic [2:0] {
    MODE_ADD   = 3'd0,
    MODE_DEL   = 3'd1,
    MODE_FLUSH = 3'd2,
    MODE_CHECK = 3'd3,
    MODE_READ  = 3'd4
  } mode_t;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_FULL      = 2'd1;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [15:0] ident;
    logic        serial_any;
    logic [63:0] serial;
    logic        product_any;
    logic [15:0] product;
    logic [15:0] vendor;
  } rule_t;

  typedef struct packed {
    logic [15:0] vendor;
    logic [15:0] product;
    logic        pwild;
    logic [63:0] serial;
    logic        swild;
    logic [15:0] target;
  } key_t;

  typedef struct packed {
    logic dev_hit;
    logic id_hit;
  } cmp_t;

endpackage

@@ src/dalt_store.sv @@
// rule memory: one write port, one read port with registered read data
// depends on dalt_pkg
module dalt_store #(
  parameter int Depth = dalt_pkg::MaxRulesDef,
  parameter int AddrW = 4
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [AddrW-1:0]  rd_addr,
  output dalt_pkg::rule_t   rd_data,
  input  logic              we,
  input  logic [AddrW-1:0]  wr_addr,
  input  dalt_pkg::rule_t   wr_data
);
  import dalt_pkg::*;

  rule_t mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ src/dalt_cmp.sv @@
// shared compare unit: one stored rule against the device key and target id
// depends on dalt_pkg
module dalt_cmp (
  input  dalt_pkg::rule_t entry,
  input  dalt_pkg::key_t  key,
  output dalt_pkg::cmp_t  res
);
  import dalt_pkg::*;

  logic vendor_eq;
  logic product_ok;
  logic serial_ok;

  assign vendor_eq  = (entry.vendor == key.vendor);
  assign product_ok = entry.product_any || (entry.product == key.product);
  // a device without a serial only passes wildcard-serial rules
  assign serial_ok  = entry.serial_any || (!key.swild && (entry.serial == key.serial));

  assign res.dev_hit = vendor_eq && product_ok && serial_ok;
  assign res.id_hit  = (entry.ident == key.target);

endmodule

@@ src/device_id_allow_list_table_core.sv @@
// device id allow-list table: sequencer, rule memory and shared compare unit
// depends on dalt_pkg, dalt_store, dalt_cmp and the assertion macro header
//
//  channel  dir  handshake          payload
//  s        in   s_tvalid/s_tready  s_tdata rule or device, s_tuser mode
//  m        out  m_tvalid/m_tready  m_tdata status, ids, count, entry
//
// add and read entry pass through ST_ADD or ST_READ to ST_OUT; flush and replies settled at
// once go straight to ST_OUT. check scans the rules in ST_SCAN, one memory read per cycle
// through the single compare unit; delete scans up to the hit, then moves the later rules
// down one place each in ST_SHIFT, and a check ends at the first matching rule.
// rst is synchronous and clears the count, sets the id counter to 1; the rule memory is
// not cleared. a new beat is taken while a result waits on m; the next one then waits.
`include "device_id_allow_list_table_core_macros.svh"

module device_id_allow_list_table_core #(
  parameter int MAX_RULES = dalt_pkg::MaxRulesDef
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // vendor_id, product_id, product_wild, serial_number, serial_wild,
  // target_id, entry_index, zero pad
  input  logic [dalt_pkg::InDataW-1:0]  s_tdata,
  // mode
  input  logic [dalt_pkg::InUserW-1:0]  s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // status, accept, result_id, rule_count, entry_vendor, entry_product,
  // entry_product_wild, entry_serial, entry_serial_wild, zero pad
  output logic [dalt_pkg::OutDataW-1:0] m_tdata
);
  import dalt_pkg::*;

  localparam int CntW  = $clog2(MAX_RULES + 1);
  localparam int AddrW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_RULES);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_SCAN,
    ST_SHIFT,
    ST_READ,
    ST_OUT
  } state_t;

  function automatic logic [63:0] norm_serial(input logic [63:0] sn);
    logic [63:0] res;
    logic        keep;
    res  = '0;
    keep = 1'b1;
    for (int b = 0; b < 8; b++) begin
      if (b >= SnBytes || sn[8*b +: 8] == 8'd0) begin
        keep = 1'b0;
      end
      if (keep) begin
        res[8*b +: 8] = sn[8*b +: 8];
      end
    end
    return res;
  endfunction

  state_t               state, state_next;
  logic [CntW-1:0]      count, count_next;
  logic [15:0]          next_id, next_id_next;
  logic [CntW-1:0]      ptr, ptr_next;
  logic                 dv, dv_next;
  logic [CntW-1:0]      didx, didx_next;
  logic [2:0]           op, op_next;
  key_t                 key, key_next;
  logic [AddrW-1:0]     key_idx, key_idx_next;
  logic [1:0]           res_status, res_status_next;
  logic                 res_accept, res_accept_next;
  logic [15:0]          res_id, res_id_next;
  logic                 res_entry, res_entry_next;
  logic                 m_tvalid_next;
  logic [OutDataW-1:0]  m_tdata_next;

  // input beat fields
  logic [2:0]           in_mode;
  logic [3:0]           in_index;
  key_t                 in_key;

  logic                 rd_en;
  logic [AddrW-1:0]     rd_addr;
  rule_t                rd_data;
  logic                 we;
  logic [AddrW-1:0]     wr_addr;
  rule_t                wr_data;
  rule_t                new_rule;
  cmp_t                 hit;

  logic [CntW-1:0]      didx_inc;
  logic [CntW-1:0]      didx_dec;
  logic [CntW+3:0]      idx_wide;
  logic [CntW+3:0]      cnt_wide;
  logic                 idx_ok;
  logic [AddrW+3:0]     idx_addr;
  logic [CntW+4:0]      cnt_ext;
  logic [OutDataW-1:0]  out_word;
  rule_t                out_entry;
  logic [15:0]          out_id;

  assign in_mode        = s_tuser;
  assign in_key.vendor  = s_tdata[15:0];
  assign in_key.product = s_tdata[31:16];
  assign in_key.pwild   = s_tdata[32];
  assign in_key.serial  = norm_serial(s_tdata[96:33]);
  assign in_key.swild   = s_tdata[97];
  assign in_key.target  = s_tdata[113:98];
  assign in_index       = s_tdata[117:114];

  assign s_tready = (state == ST_IDLE);

  assign didx_inc = didx + CntW'(1);
  assign didx_dec = didx - CntW'(1);
  assign idx_wide = {{CntW{1'b0}}, in_index};
  assign cnt_wide = {4'b0000, count};
  assign idx_ok   = (idx_wide < cnt_wide);
  assign idx_addr = {{AddrW{1'b0}}, in_index};
  assign cnt_ext  = {5'b00000, count};

  assign new_rule.ident       = next_id;
  assign new_rule.serial_any  = key.swild;
  assign new_rule.serial      = key.serial;
  assign new_rule.product_any = key.pwild;
  assign new_rule.product     = key.product;
  assign new_rule.vendor      = key.vendor;

  assign out_entry = res_entry ? rd_data : '0;
  assign out_id    = res_entry ? rd_data.ident : res_id;
  assign out_word  = {6'b000000, out_entry.serial_any, out_entry.serial,
                      out_entry.product_any, out_entry.product, out_entry.vendor,
                      cnt_ext[4:0], out_id, res_accept, res_status};

  dalt_store #(
    .Depth (MAX_RULES),
    .AddrW (AddrW)
  ) u_store (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .we      (we),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  dalt_cmp u_cmp (
    .entry (rd_data),
    .key   (key),
    .res   (hit)
  );

  always_comb begin
    state_next      = state;
    count_next      = count;
    next_id_next    = next_id;
    ptr_next        = ptr;
    dv_next         = dv;
    didx_next       = didx;
    op_next         = op;
    key_next        = key;
    key_idx_next    = key_idx;
    res_status_next = res_status;
    res_accept_next = res_accept;
    res_id_next     = res_id;
    res_entry_next  = res_entry;
    m_tvalid_next   = m_tvalid & ~m_tready;
    m_tdata_next    = m_tdata;
    rd_en           = 1'b0;
    rd_addr         = ptr[AddrW-1:0];
    we              = 1'b0;
    wr_addr         = count[AddrW-1:0];
    wr_data         = new_rule;

    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          op_next         = in_mode;
          key_next        = in_key;
          key_idx_next    = idx_addr[AddrW-1:0];
          res_status_next = STAT_OK;
          res_accept_next = 1'b0;
          res_id_next     = 16'd0;
          res_entry_next  = 1'b0;
          ptr_next        = '0;
          dv_next         = 1'b0;
          state_next      = ST_OUT;
          case (in_mode)
            MODE_ADD: begin
              state_next = ST_ADD;
            end
            MODE_DEL: begin
              res_status_next = STAT_NOT_FOUND;
              if (count != '0) begin
                state_next = ST_SCAN;
              end
            end
            MODE_FLUSH: begin
              count_next   = '0;
              next_id_next = 16'd1;
            end
            MODE_CHECK: begin
              // an empty table lets every device through
              if (count == '0) begin
                res_accept_next = 1'b1;
              end else begin
                state_next = ST_SCAN;
              end
            end
            MODE_READ: begin
              if (idx_ok) begin
                state_next = ST_READ;
              end else begin
                res_status_next = STAT_NOT_FOUND;
              end
            end
            default: begin
              res_status_next = STAT_NOT_FOUND;
            end
          endcase
        end
      end

      ST_ADD: begin
        if (count >= MaxCnt) begin
          res_status_next = STAT_FULL;
        end else begin
          we           = 1'b1;
          res_id_next  = next_id;
          next_id_next = next_id + 16'd1;
          count_next   = count + CntW'(1);
        end
        state_next = ST_OUT;
      end

      ST_SCAN: begin
        // read one rule ahead of the compare
        if (ptr < count) begin
          rd_en    = 1'b1;
          ptr_next = ptr + CntW'(1);
        end
        dv_next   = (ptr < count);
        didx_next = ptr;
        if (dv) begin
          if (op == MODE_CHECK && hit.dev_hit) begin
            res_accept_next = 1'b1;
            dv_next         = 1'b0;
            state_next      = ST_OUT;
          end else if (op == MODE_DEL && hit.id_hit) begin
            res_status_next = STAT_OK;
            dv_next         = 1'b0;
            if (didx_inc == count) begin
              count_next = count - CntW'(1);
              state_next = ST_OUT;
            end else begin
              ptr_next   = didx_inc;
              state_next = ST_SHIFT;
            end
          end else if (didx_inc == count) begin
            dv_next    = 1'b0;
            state_next = ST_OUT;
          end
        end
      end

      ST_SHIFT: begin
        // close the gap: rule at didx moves down to didx - 1
        if (ptr < count) begin
          rd_en    = 1'b1;
          ptr_next = ptr + CntW'(1);
        end
        dv_next   = (ptr < count);
        didx_next = ptr;
        if (dv) begin
          we      = 1'b1;
          wr_addr = didx_dec[AddrW-1:0];
          wr_data = rd_data;
          if (didx_inc == count) begin
            count_next = count - CntW'(1);
            dv_next    = 1'b0;
            state_next = ST_OUT;
          end
        end
      end

      ST_READ: begin
        rd_en          = 1'b1;
        rd_addr        = key_idx;
        res_entry_next = 1'b1;
        state_next     = ST_OUT;
      end

      ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          m_tvalid_next = 1'b1;
          m_tdata_next  = out_word;
          state_next    = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      next_id  <= 16'd1;
      dv       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      next_id  <= next_id_next;
      dv       <= dv_next;
      m_tvalid <= m_tvalid_next;
    end
    ptr        <= ptr_next;
    didx       <= didx_next;
    op         <= op_next;
    key        <= key_next;
    key_idx    <= key_idx_next;
    res_status <= res_status_next;
    res_accept <= res_accept_next;
    res_id     <= res_id_next;
    res_entry  <= res_entry_next;
    m_tdata    <= m_tdata_next;
  end

  `DALT_CHK(a_count_bound, count <= MaxCnt, "rule count above table size")
  `DALT_CHK(a_port_clash, !(rd_en && we && rd_addr == wr_addr), "read and write hit one entry")
  `DALT_CHK(a_dv_state, !dv || state == ST_SCAN || state == ST_SHIFT, "stale read data flag")
  `DALT_CHK_NEXT(a_id_step, state == ST_ADD && count < MaxCnt,
                 next_id == 16'($past(next_id) + 16'd1), "id counter not advanced on add")

endmodule

@@ dv/allow_list_checker.sv @@
// checker for the device id allow-list table: keeps its own copy of the rule table,
// predicts one reply per accepted command beat and compares it with the m side
// depends on dalt_pkg
module allow_list_checker
  import dalt_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  logic                s_tready,
  input  logic [InDataW-1:0]  s_tdata,
  input  logic [InUserW-1:0]  s_tuser,
  input  logic                m_tvalid,
  input  logic                m_tready,
  input  logic [OutDataW-1:0] m_tdata,
  output int                  mismatches,
  output int                  outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  status;
    logic        accept;
    logic [15:0] result_id;
    logic [4:0]  rule_count;
    logic [15:0] vendor;
    logic [15:0] product;
    logic        product_wild;
    logic [63:0] serial;
    logic        serial_wild;
  } table_reply_t;

  rule_t        table_rules [MaxRulesDef];
  int           rules_used = 0;
  logic [15:0]  next_ident = 16'd1;
  table_reply_t expected_replies [$];

  initial mismatches = 0;
  initial outstanding = 0;

  task automatic report_failure(string msg);
    $display("%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic compare_field(string what, logic [63:0] got, logic [63:0] want);
    if (got !== want)
      report_failure($sformatf("%s: got %0h, expected %0h", what, got, want));
  endtask

  // applies one command to the shadow table and returns the reply it should give
  function automatic table_reply_t apply_table_op(logic [2:0] op, logic [InDataW-1:0] d);
    table_reply_t r;
    logic [15:0]  vid, pid, tid;
    logic         pw, sw, ended;
    logic [63:0]  sn;
    int           idx, hit, i, b;
    r = '0;
    vid = d[15:0];
    pid = d[31:16];
    pw  = d[32];
    sw  = d[97];
    tid = d[113:98];
    idx = int'(d[117:114]);
    // a serial ends at its first zero byte
    sn = '0;
    ended = 1'b0;
    for (b = 0; b < SnBytes; b++) begin
      if (d[33 + 8 * b +: 8] == 8'h00) ended = 1'b1;
      if (!ended) sn[8 * b +: 8] = d[33 + 8 * b +: 8];
    end
    case (op)
      MODE_ADD: begin
        if (rules_used >= MaxRulesDef) begin
          r.status = STAT_FULL;
        end else begin
          table_rules[rules_used] = '{ident: next_ident, serial_any: sw, serial: sn,
                                      product_any: pw, product: pid, vendor: vid};
          r.result_id = next_ident;
          next_ident++;
          rules_used++;
        end
      end
      MODE_DEL: begin
        hit = -1;
        for (i = 0; i < rules_used; i++)
          if (hit < 0 && table_rules[i].ident == tid) hit = i;
        if (hit < 0) begin
          r.status = STAT_NOT_FOUND;
        end else begin
          for (i = hit; i + 1 < rules_used; i++) table_rules[i] = table_rules[i + 1];
          rules_used--;
        end
      end
      MODE_FLUSH: begin
        rules_used = 0;
        next_ident = 16'd1;
      end
      MODE_CHECK: begin
        r.accept = (rules_used == 0);
        for (i = 0; i < rules_used; i++)
          if (table_rules[i].vendor == vid &&
              (table_rules[i].product_any || table_rules[i].product == pid) &&
              (table_rules[i].serial_any || (!sw && table_rules[i].serial == sn)))
            r.accept = 1'b1;
      end
      MODE_READ: begin
        if (idx < rules_used) begin
          r.result_id    = table_rules[idx].ident;
          r.vendor       = table_rules[idx].vendor;
          r.product      = table_rules[idx].product;
          r.product_wild = table_rules[idx].product_any;
          r.serial       = table_rules[idx].serial;
          r.serial_wild  = table_rules[idx].serial_any;
        end else begin
          r.status = STAT_NOT_FOUND;
        end
      end
      default: r.status = STAT_NOT_FOUND;
    endcase
    r.rule_count = 5'(rules_used);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    table_reply_t got, want;
    if (rst) begin
      expected_replies.delete();
      rules_used = 0;
      next_ident = 16'd1;
    end else begin
      if (m_tvalid && m_tready) begin
        got.status       = m_tdata[1:0];
        got.accept       = m_tdata[2];
        got.result_id    = m_tdata[18:3];
        got.rule_count   = m_tdata[23:19];
        got.vendor       = m_tdata[39:24];
        got.product      = m_tdata[55:40];
        got.product_wild = m_tdata[56];
        got.serial       = m_tdata[120:57];
        got.serial_wild  = m_tdata[121];
        if (expected_replies.size() == 0) begin
          report_failure("result beat with no command outstanding");
        end else begin
          want = expected_replies.pop_front();
          compare_field("status", got.status, want.status);
          compare_field("accept", got.accept, want.accept);
          compare_field("result_id", got.result_id, want.result_id);
          compare_field("rule_count", got.rule_count, want.rule_count);
          compare_field("entry_vendor", got.vendor, want.vendor);
          compare_field("entry_product", got.product, want.product);
          compare_field("entry_product_wild", got.product_wild, want.product_wild);
          compare_field("entry_serial", got.serial, want.serial);
          compare_field("entry_serial_wild", got.serial_wild, want.serial_wild);
        end
      end
      if (s_tvalid && s_tready) expected_replies.push_back(apply_table_op(s_tuser, s_tdata));
    end
    outstanding <= expected_replies.size();
  end

endmodule

@@ dv/device_id_allow_list_table_core_tb.sv @@
// testbench top for device_id_allow_list_table_core: clock, reset, command stimulus,
// receiver back-pressure and the final verdict
// depends on dalt_pkg, the table core and allow_list_checker
module device_id_allow_list_table_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dalt_pkg::*;

  localparam int unsigned CycleLimit = 4_000_000;

  typedef struct packed {
    logic [3:0]  idx;
    logic [15:0] tid;
    logic        sw;
    logic [63:0] sn;
    logic        pw;
    logic [15:0] pid;
    logic [15:0] vid;
  } command_t;

  typedef enum int {RX_FREE, RX_COIN, RX_SPARSE, RX_HEAVY} rx_style_e;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata = '0;
  logic [InUserW-1:0]  s_tuser = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  int                  mismatches;
  int                  outstanding;
  int unsigned         cycle_count = 0;
  int                  burst_left = 0;
  bit                  hold_req = 1'b0;
  bit                  hold_done = 1'b0;

  always #2 clk = ~clk;

  device_id_allow_list_table_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  allow_list_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic command_t any_fields();
    command_t c;
    c.vid = 16'($urandom);
    c.pid = 16'($urandom);
    c.pw  = 1'($urandom);
    c.sn  = {$urandom, $urandom};
    c.sw  = 1'($urandom);
    c.tid = 16'($urandom);
    c.idx = 4'($urandom);
    return c;
  endfunction

  // offers one beat, with a random gap in front of each burst
  task automatic send_op(logic [2:0] op, command_t c);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 10);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {2'b00, c};
    do @(posedge clk); while (!s_tready);
  endtask

  initial begin : receiver
    rx_style_e style;
    int        style_left, hold_left;
    style = RX_FREE;
    style_left = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_left = 400;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        if (style_left == 0) begin
          style = rx_style_e'($urandom_range(0, 3));
          style_left = $urandom_range(20, 150);
        end
        style_left--;
        case (style)
          RX_FREE:   m_tready <= 1'b1;
          RX_COIN:   m_tready <= 1'($urandom);
          RX_SPARSE: m_tready <= ($urandom_range(0, 7) != 0);
          default:   m_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    command_t    c, last_added;
    logic [2:0]  op;
    logic [15:0] vendor_pool [4];
    logic [15:0] product_pool [4];
    logic [63:0] serial_pool [4];
    int          n, k, j, z, pick, len, adds_since_flush;

    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // check on an empty table, then fill it to the top
    send_op(MODE_CHECK, any_fields());
    for (k = 0; k < MaxRulesDef; k++) begin
      c = any_fields();
      case (k)
        0: begin
          c.vid = '0; c.pid = '0; c.pw = 1'b0; c.sn = '0; c.sw = 1'b0;
        end
        1: begin
          c.vid = '1; c.pid = '1; c.pw = 1'b0; c.sn = '1; c.sw = 1'b0;
        end
        2: begin
          // zero byte early on, rubbish after it
          c.vid = 16'hA5A5; c.pw = 1'b1; c.sn = 64'hDEAD_BEEF_0000_4241; c.sw = 1'b0;
        end
        3: begin
          c.vid = 16'h1234; c.pid = 16'h5678; c.pw = 1'b0; c.sw = 1'b1;
        end
        default: ;
      endcase
      send_op(MODE_ADD, c);
    end
    send_op(MODE_ADD, any_fields());

    // device without serial against a serial-wildcard rule and a fixed-serial rule, then devices with a serial
    c = any_fields();
    c.vid = 16'h1234; c.pid = 16'h5678; c.sw = 1'b1;
    send_op(MODE_CHECK, c);
    c = any_fields();
    c.vid = '1; c.pid = '1; c.sw = 1'b1;
    send_op(MODE_CHECK, c);
    c = any_fields();
    c.vid = 16'hA5A5; c.sn = 64'h1111_2222_3300_4241; c.sw = 1'b0;
    send_op(MODE_CHECK, c);
    c = any_fields();
    c.vid = '1; c.pid = '1; c.sn = '1; c.sw = 1'b0;
    send_op(MODE_CHECK, c);

    c = any_fields();
    c.idx = '0;
    send_op(MODE_READ, c);
    c.idx = '1;
    send_op(MODE_READ, c);
    c.tid = 16'd2;
    send_op(MODE_DEL, c);
    send_op(MODE_READ, c);
    c.tid = '1;
    send_op(MODE_DEL, c);
    send_op(3'(MODE_READ) + 3'($urandom_range(1, 3)), any_fields());
    send_op(MODE_FLUSH, any_fields());

    // random traffic drawn mostly from small pools so that checks and deletes hit
    for (k = 0; k < 4; k++) begin
      vendor_pool[k] = 16'($urandom);
      product_pool[k] = 16'($urandom);
      len = $urandom_range(0, 8);
      serial_pool[k] = '0;
      for (j = 0; j < len; j++) serial_pool[k][8 * j +: 8] = 8'($urandom_range(1, 255));
    end
    adds_since_flush = 0;
    last_added = any_fields();
    for (n = 0; n < 520; n++) begin
      if (n == 60) hold_req = 1'b1;
      c = any_fields();
      if ($urandom_range(0, 3) != 0) c.vid = vendor_pool[$urandom_range(0, 3)];
      if ($urandom_range(0, 3) != 0) c.pid = product_pool[$urandom_range(0, 3)];
      if ($urandom_range(0, 3) != 0) begin
        c.sn = serial_pool[$urandom_range(0, 3)];
        if ($urandom_range(0, 2) == 0) begin
          z = 8;
          for (j = 7; j >= 0; j--) if (c.sn[8 * j +: 8] == 8'h00) z = j;
          for (j = z + 1; j < 8; j++) c.sn[8 * j +: 8] = 8'($urandom);
        end
      end
      c.pw = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 199);
      if (pick < 4) begin
        op = 3'(MODE_READ) + 3'($urandom_range(1, 3));
      end else if (pick < 7) begin
        op = MODE_FLUSH;
        adds_since_flush = 0;
      end else if (pick < 77) begin
        op = MODE_ADD;
        c.sw = ($urandom_range(0, 3) == 0);
        last_added = c;
        adds_since_flush++;
      end else if (pick < 107) begin
        op = MODE_DEL;
        if (adds_since_flush > 0 && $urandom_range(0, 4) != 0)
          c.tid = 16'($urandom_range(1, adds_since_flush + 1));
      end else if (pick < 167) begin
        op = MODE_CHECK;
        if ($urandom_range(0, 2) == 0) begin
          c.vid = last_added.vid;
          c.pid = last_added.pid;
          c.sn  = last_added.sn;
        end
      end else begin
        op = MODE_READ;
      end
      send_op(op, c);
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    wait (outstanding == 0);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+src
src/dalt_pkg.sv
src/dalt_store.sv
src/dalt_cmp.sv
src/device_id_allow_list_table_core.sv
dv/allow_list_checker.sv
dv/device_id_allow_list_table_core_tb.sv
